// ===== src/posterior_scatter_accumulator_macros.svh =====
// Assertion helpers for the posterior scatter accumulator.
`ifndef POSTERIOR_SCATTER_ACCUMULATOR_MACROS_SVH
`define POSTERIOR_SCATTER_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, muted while reset is held.
`define PSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psa assertion failed");

// Next-cycle implication, muted while reset is held.
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psa assertion failed");

`endif

// ===== src/psa_pkg.sv =====
`default_nettype none
package psa_pkg;

    localparam int ROWS_A_DEF = 256;
    localparam int COLS_B_DEF = 256;

    localparam int MAP_DEPTH = 256;
    localparam int MAP_AW    = 8;
    localparam int COL_W     = 8;
    localparam int PROB_W    = 16;
    localparam int CELL_W    = 32;
    localparam int CFG_W     = 8;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_ACC    = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_LAST_A = 1'b0,
        CFG_LAST_B = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } t_state;

    // One map memory port set: a write and a registered read.
    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic [COL_W-1:0]  wdata;
        logic              re;
        logic [MAP_AW-1:0] raddr;
    } t_map_req;

endpackage
`default_nettype wire

// ===== src/posterior_scatter_accumulator.sv =====
`default_nettype none
// Posterior scatter accumulator: sums sparse pairwise posteriors (unsigned
// Q0.16) into a dense ROWS_A x COLS_B matrix of unsigned Q16.16 cells held in
// one synchronous cell memory; two 256-entry map memories turn sequence
// positions into alignment columns. Commands: load an A map entry, load a B
// map entry, accumulate one sparse entry (clipped at the cell maximum, refused
// with range_error when a mapped column lies beyond the length registers or
// the store), and read-and-clear one cell. Every input word yields one output
// word. Each word is accepted while both maps are read, then looks up the
// cell, then is modified, written back and posted as the result, this last
// step waiting while the output register is held; only one word is in flight,
// so reads and write-backs of the same cell never overlap. After reset the
// cell memory is cleared one entry a cycle, during which input is stalled;
// the length registers may be written at any time the block is idle.
module posterior_scatter_accumulator #(
    parameter int ROWS_A = psa_pkg::ROWS_A_DEF,
    parameter int COLS_B = psa_pkg::COLS_B_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    // configuration write port
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [psa_pkg::CFG_W-1:0]   i_cfg_data,

    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_command,
    input  wire logic [psa_pkg::COL_W-1:0]   i_row_position,
    input  wire logic [psa_pkg::COL_W-1:0]   i_col_position,
    input  wire logic [psa_pkg::COL_W-1:0]   i_column_value,
    input  wire logic [psa_pkg::PROB_W-1:0]  i_probability,
    input  wire logic                        i_transposed,

    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [psa_pkg::CELL_W-1:0]       o_cell_value,
    output logic                             o_read_valid,
    output logic                             o_range_error,
    output logic                             o_saturated
);
    import psa_pkg::*;

    localparam int CELLS   = ROWS_A * COLS_B;
    localparam int CELL_AW = $clog2(CELLS);
    localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(CELLS - 1);

    // An 8-bit column can only fall outside the store when the store is
    // narrower than 256 on that side.
    localparam bit               A_NARROW = (ROWS_A < 256);
    localparam bit               B_NARROW = (COLS_B < 256);
    localparam logic [COL_W-1:0] A_LIM    = A_NARROW ? COL_W'(ROWS_A) : '1;
    localparam logic [COL_W-1:0] B_LIM    = B_NARROW ? COL_W'(COLS_B) : '1;

    // ---------------------------------------------------------------
    // Length registers
    // ---------------------------------------------------------------
    logic [COL_W-1:0] r_last_a;
    logic [COL_W-1:0] r_last_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a <= '1;
            r_last_b <= '1;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LAST_A: r_last_a <= i_cfg_data;
                CFG_LAST_B: r_last_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic w_in_acc;
    logic w_out_free;
    logic w_post;
    logic w_cell_re;

    logic [CELL_AW-1:0] r_clr_addr;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    // The output register is free when empty or being taken this cycle.
    assign w_out_free = !o_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == CELL_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_cell_re  = 1'b0;
        w_post     = 1'b0;
        case (r_state)
            ST_IDLE:   o_in_stall = 1'b0;
            ST_LOOK:   w_cell_re  = 1'b1;
            ST_UPDATE: w_post     = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Clearing pass address: sweep the whole cell store once after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Held input word
    // ---------------------------------------------------------------
    t_cmd                r_cmd;
    logic [COL_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [PROB_W-1:0]   r_prob;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd  <= t_cmd'(i_command);
            r_row  <= i_row_position;
            r_col  <= i_col_position;
            r_prob <= i_probability;
        end
    end

    // ---------------------------------------------------------------
    // Map memories: load on accept, or look up both positions on accept
    // ---------------------------------------------------------------
    t_map_req         w_map_a_req;
    t_map_req         w_map_b_req;
    logic [COL_W-1:0] w_map_a_q;
    logic [COL_W-1:0] w_map_b_q;

    always_comb begin
        w_map_a_req.we    = w_in_acc && (t_cmd'(i_command) == CMD_LOAD_A);
        w_map_a_req.waddr = i_row_position;
        w_map_a_req.wdata = i_column_value;
        w_map_a_req.re    = w_in_acc;
        w_map_a_req.raddr = i_transposed ? i_col_position : i_row_position;

        w_map_b_req.we    = w_in_acc && (t_cmd'(i_command) == CMD_LOAD_B);
        w_map_b_req.waddr = i_row_position;
        w_map_b_req.wdata = i_column_value;
        w_map_b_req.re    = w_in_acc;
        w_map_b_req.raddr = i_transposed ? i_row_position : i_col_position;
    end

    psa_map_ram u_map_a (
        .i_clk   (i_clk),
        .i_req   (w_map_a_req),
        .o_rdata (w_map_a_q)
    );

    psa_map_ram u_map_b (
        .i_clk   (i_clk),
        .i_req   (w_map_b_req),
        .o_rdata (w_map_b_q)
    );

    // ---------------------------------------------------------------
    // Cell look-up: pick the cell, check its columns, read it
    // ---------------------------------------------------------------
    logic               w_is_acc;
    logic               w_is_read;
    logic [COL_W-1:0]   w_ca;
    logic [COL_W-1:0]   w_cb;
    logic               w_oob;
    logic [CELL_AW-1:0] w_idx;

    assign w_is_acc  = (r_cmd == CMD_ACC);
    assign w_is_read = (r_cmd == CMD_READ);
    // Reads address the cell directly; accumulates go through the maps.
    assign w_ca      = w_is_read ? r_row : w_map_a_q;
    assign w_cb      = w_is_read ? r_col : w_map_b_q;

    always_comb begin
        w_oob = (A_NARROW && (w_ca >= A_LIM)) || (B_NARROW && (w_cb >= B_LIM));
        // Length registers only gate accumulates.
        if (w_is_acc && ((w_ca > r_last_a) || (w_cb > r_last_b))) begin
            w_oob = 1'b1;
        end
    end

    assign w_idx = CELL_AW'(w_ca) * CELL_AW'(COLS_B) + CELL_AW'(w_cb);

    logic               r_err;
    logic [CELL_AW-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (w_cell_re) begin
            r_err <= (w_is_acc || w_is_read) && w_oob;
            r_idx <= w_idx;
        end
    end

    // ---------------------------------------------------------------
    // Cell update: add with clipping, or clear after a read
    // ---------------------------------------------------------------
    logic [CELL_W-1:0]  w_cell_q;
    logic [CELL_W:0]    w_sum;
    logic               w_sat;
    logic [CELL_W-1:0]  w_new;
    logic               w_wb;
    logic               w_cell_we;
    logic [CELL_AW-1:0] w_cell_waddr;
    logic [CELL_W-1:0]  w_cell_wdata;

    assign w_sum = {1'b0, w_cell_q} + (CELL_W + 1)'(r_prob);
    assign w_sat = w_sum[CELL_W];
    assign w_new = w_is_read ? '0 : (w_sat ? '1 : w_sum[CELL_W-1:0]);
    assign w_wb  = w_post && (w_is_acc || w_is_read) && !r_err;

    // The clearing pass owns the write port until it completes.
    assign w_cell_we    = (r_state == ST_CLEAR) || w_wb;
    assign w_cell_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_idx;
    assign w_cell_wdata = (r_state == ST_CLEAR) ? '0 : w_new;

    psa_cell_ram #(
        .DEPTH (CELLS),
        .AW    (CELL_AW)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_cell_we),
        .i_waddr (w_cell_waddr),
        .i_wdata (w_cell_wdata),
        .i_re    (w_cell_re),
        .i_raddr (w_idx),
        .o_rdata (w_cell_q)
    );

    // ---------------------------------------------------------------
    // Output register: hold the result word until taken
    // ---------------------------------------------------------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_post) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    logic [CELL_W-1:0] r_cell_value;
    logic              r_read_valid;
    logic              r_range_error;
    logic              r_saturated;

    always_ff @(posedge i_clk) begin
        if (w_post) begin
            r_cell_value  <= (w_is_read && !r_err) ? w_cell_q : '0;
            r_read_valid  <= w_is_read && !r_err;
            r_range_error <= r_err;
            r_saturated   <= w_is_acc && !r_err && w_sat;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_value  = r_cell_value;
    assign o_read_valid  = r_read_valid;
    assign o_range_error = r_range_error;
    assign o_saturated   = r_saturated;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`include "posterior_scatter_accumulator_macros.svh"

    // An accepted word always moves on to the cell look-up.
    `PSA_ASSERT_NEXT(a_accept_to_look, i_clk, i_rst_n, w_in_acc, r_state == ST_LOOK)
    // No result word may appear while the store is still being cleared.
    `PSA_ASSERT_NOW(a_clear_quiet, i_clk, i_rst_n, r_state == ST_CLEAR, !r_out_valid)
    // A blocked result keeps the update stage parked.
    `PSA_ASSERT_NEXT(a_update_waits, i_clk, i_rst_n,
        (r_state == ST_UPDATE) && !w_out_free, r_state == ST_UPDATE)
    // Clipping only comes from a successful accumulate.
    `PSA_ASSERT_NOW(a_sat_alone, i_clk, i_rst_n, r_out_valid && r_saturated,
        !r_range_error && !r_read_valid)

endmodule
`default_nettype wire

// ===== src/psa_map_ram.sv =====
`default_nettype none
module psa_map_ram (
    input  wire logic                    i_clk,
    input  wire psa_pkg::t_map_req       i_req,
    output logic [psa_pkg::COL_W-1:0]    o_rdata
);
    import psa_pkg::*;

    logic [COL_W-1:0] r_mem [MAP_DEPTH];
    logic [COL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== src/psa_cell_ram.sv =====
`default_nettype none
module psa_cell_ram #(
    parameter int DEPTH = psa_pkg::ROWS_A_DEF * psa_pkg::COLS_B_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [psa_pkg::CELL_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic [psa_pkg::CELL_W-1:0]     o_rdata
);
    import psa_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire
